// File: rtl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types and constants of the per-source resequencer.
// ----------------------------------------------------------------------------
package rps_pkg;

	localparam int MAX_RESULTS = 16;

	typedef enum logic [1:0] {
		KIND_DELIVERED = 2'd0,
		KIND_BUFFERED  = 2'd1,
		KIND_STALE     = 2'd2,
		KIND_BEYOND    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DELIVER,
		ST_FETCH,
		ST_RESULT,
		ST_WRITEBACK
	} st_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} mem_ctl_t;

endpackage

// File: rtl/rps_msg_if.sv
// ----------------------------------------------------------------------------
// rps_msg_if
// Request channel: source index, sequence number and payload word.
// ----------------------------------------------------------------------------
interface rps_msg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  source_id;
	logic [31:0] seq_num;
	logic [63:0] payload;

	modport source (output valid, output source_id, output seq_num, output payload,
		input ready);
	modport sink (input valid, input source_id, input seq_num, input payload,
		output ready);
endinterface

// File: rtl/rps_res_if.sv
// ----------------------------------------------------------------------------
// rps_res_if
// Result channel: kind, global stamp, source, payload and last flag.
// ----------------------------------------------------------------------------
interface rps_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] global_seq;
	logic [3:0]  out_source;
	logic [63:0] out_payload;
	logic        last;

	modport source (output valid, output kind, output global_seq, output out_source,
		output out_payload, output last, input ready);
	modport sink (input valid, input kind, input global_seq, input out_source,
		input out_payload, input last, output ready);
endinterface

// File: rtl/rps_src_table.sv
// ----------------------------------------------------------------------------
// rps_src_table
// Per-source state memory: expected number, window base and slot valid bits.
// A row never written reads as zero through its row valid flop.
// ----------------------------------------------------------------------------
module rps_src_table #(
	parameter int WINDOW  = 16,
	parameter int SOURCES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rps_pkg::mem_ctl_t           ctl,
	input  logic [3:0]                  rd_src,
	output logic [31:0]                 rd_exp,
	output logic [$clog2(WINDOW)-1:0]   rd_base,
	output logic [WINDOW-1:0]           rd_vec,
	input  logic [3:0]                  wr_src,
	input  logic [31:0]                 wr_exp,
	input  logic [$clog2(WINDOW)-1:0]   wr_base,
	input  logic [WINDOW-1:0]           wr_vec
);
	import rps_pkg::*;

	localparam int BW = $clog2(WINDOW);
	localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int EW = 32 + BW + WINDOW;

	logic [EW-1:0]      mem [SOURCES];
	logic [EW-1:0]      rdata_q;
	logic               hit_q;
	logic [SOURCES-1:0] row_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[SW'(wr_src)] <= {wr_exp, wr_base, wr_vec};
		end
		if (ctl.rd) begin
			rdata_q <= mem[SW'(rd_src)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (ctl.wr) begin
				row_vld_q[SW'(wr_src)] <= 1'b1;
			end
			if (ctl.rd) begin
				hit_q <= row_vld_q[SW'(rd_src)];
			end
		end
	end

	assign rd_exp  = hit_q ? rdata_q[EW-1 -: 32]        : 32'd0;
	assign rd_base = hit_q ? rdata_q[WINDOW +: BW]      : '0;
	assign rd_vec  = hit_q ? rdata_q[WINDOW-1:0]        : '0;

endmodule

// File: rtl/rps_slot_store.sv
// ----------------------------------------------------------------------------
// rps_slot_store
// Slot payload memory, one row of window slots per source.
// ----------------------------------------------------------------------------
module rps_slot_store #(
	parameter int WINDOW  = 16,
	parameter int SOURCES = 16
) (
	input  logic                        clk,
	input  rps_pkg::mem_ctl_t           ctl,
	input  logic [3:0]                  src,
	input  logic [$clog2(WINDOW)-1:0]   slot,
	input  logic [63:0]                 wdata,
	output logic [63:0]                 rdata
);
	import rps_pkg::*;

	localparam int SW    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int DEPTH = SOURCES * WINDOW;
	localparam int AW    = $clog2(DEPTH);

	logic [63:0]   mem [DEPTH];
	logic [63:0]   rdata_q;
	logic [AW-1:0] addr;

	// row times window plus slot
	assign addr = AW'(AW'(SW'(src)) * AW'(WINDOW)) + AW'(slot);

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/per_source_resequencer.sv
// ----------------------------------------------------------------------------
// per_source_resequencer
// Reorders messages of each source by sequence number and stamps delivered
// messages with a global sequence counter.
//
// Channels: msg takes one request (source, sequence number, payload); res
// gives the results of that request, the final one flagged by last. Kind is
// delivered, buffered, stale or beyond window. A source index at or above
// SOURCES is taken and gives no result.
// Timing: one request at a time. A buffered request goes through look-up,
// result and write-back before the next acceptance, a dropped one through
// look-up and result only. In a request that releases messages, each
// message after the first costs one read of the slot payload memory, and
// the per-source row is read once and written back once for that request.
// Reset: the per-source row valid flops clear at once, so every source starts
// with expected number zero and an empty window; no clearing pass is run.
// Stall: results sit in an output register; while res is stalled the next
// request can still be taken and looked up, then the block holds its state
// and waits until the pending result has moved.
// ----------------------------------------------------------------------------
module per_source_resequencer #(
	parameter int WINDOW  = 16,
	parameter int SOURCES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rps_msg_if.sink   msg,
	rps_res_if.source res
);
	import rps_pkg::*;

	localparam int BW    = $clog2(WINDOW);
	localparam int LIMIT = (WINDOW < MAX_RESULTS) ? WINDOW : MAX_RESULTS;
	localparam int CW    = $clog2(LIMIT + 1);

	st_t            st_q, st_d;
	logic [3:0]     src_q;
	logic [31:0]    seq_q;
	logic [63:0]    pl_q;
	logic [31:0]    exp_q;
	logic [BW-1:0]  base_q;
	logic [WINDOW-1:0] vec_q;
	logic [CW-1:0]  cnt_q;
	logic           first_q;
	kind_t          kind_q;
	logic [31:0]    gcnt_q;

	logic           out_valid_q;
	kind_t          out_kind_q;
	logic [31:0]    out_gseq_q;
	logic [3:0]     out_src_q;
	logic [63:0]    out_pl_q;
	logic           out_last_q;

	mem_ctl_t       tbl_ctl, slot_ctl;
	logic [31:0]    rd_exp;
	logic [BW-1:0]  rd_base;
	logic [WINDOW-1:0] rd_vec;
	logic [63:0]    slot_rdata;
	logic [BW-1:0]  slot_idx;

	logic           accept, in_range, out_free, out_load;
	logic           seq_eq, seq_gt, in_win;
	logic [31:0]    diff;
	logic [BW:0]    idx_sum;
	logic [BW-1:0]  look_idx;
	logic [BW-1:0]  nxt_base;
	logic           last_d;
	kind_t          out_kind_d;
	logic [31:0]    out_gseq_d;
	logic [63:0]    out_pl_d;
	logic           out_last_d;

	rps_src_table #(.WINDOW(WINDOW), .SOURCES(SOURCES)) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.rd_src  (msg.source_id),
		.rd_exp  (rd_exp),
		.rd_base (rd_base),
		.rd_vec  (rd_vec),
		.wr_src  (src_q),
		.wr_exp  (exp_q),
		.wr_base (base_q),
		.wr_vec  (vec_q)
	);

	rps_slot_store #(.WINDOW(WINDOW), .SOURCES(SOURCES)) u_slots (
		.clk   (clk),
		.ctl   (slot_ctl),
		.src   (src_q),
		.slot  (slot_idx),
		.wdata (pl_q),
		.rdata (slot_rdata)
	);

	// classification of the looked-up request
	assign seq_eq   = (seq_q == rd_exp);
	assign seq_gt   = (seq_q > rd_exp);
	assign diff     = seq_q - rd_exp;
	assign in_win   = (diff < 32'(WINDOW));
	assign idx_sum  = (BW+1)'(rd_base) + (BW+1)'(diff[BW-1:0]);
	assign look_idx = (idx_sum >= (BW+1)'(WINDOW)) ? BW'(idx_sum - (BW+1)'(WINDOW))
		: BW'(idx_sum);

	assign nxt_base = (base_q == BW'(WINDOW - 1)) ? '0 : base_q + BW'(1);
	assign last_d   = (cnt_q == CW'(LIMIT - 1)) || !vec_q[nxt_base];

	assign in_range = (32'(msg.source_id) < SOURCES);
	assign out_free = !out_valid_q || res.ready;
	assign accept   = msg.valid && msg.ready;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (accept && in_range) st_d = ST_LOOK;
			end
			ST_LOOK: begin
				st_d = seq_eq ? ST_DELIVER : ST_RESULT;
			end
			ST_DELIVER: begin
				if (out_free) st_d = last_d ? ST_WRITEBACK : ST_FETCH;
			end
			ST_FETCH: begin
				st_d = ST_DELIVER;
			end
			ST_RESULT: begin
				if (out_free) st_d = (kind_q == KIND_BUFFERED) ? ST_WRITEBACK : ST_IDLE;
			end
			ST_WRITEBACK: begin
				st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		msg.ready   = 1'b0;
		tbl_ctl     = '0;
		slot_ctl    = '0;
		slot_idx    = base_q;
		out_load    = 1'b0;
		out_kind_d  = kind_q;
		out_gseq_d  = 32'd0;
		out_pl_d    = 64'd0;
		out_last_d  = 1'b1;
		unique case (st_q)
			ST_IDLE: begin
				msg.ready  = 1'b1;
				tbl_ctl.rd = msg.valid && in_range;
			end
			ST_LOOK: begin
				slot_idx    = look_idx;
				slot_ctl.wr = seq_gt && in_win;
			end
			ST_DELIVER: begin
				out_load   = out_free;
				out_kind_d = KIND_DELIVERED;
				out_gseq_d = gcnt_q;
				out_pl_d   = first_q ? pl_q : slot_rdata;
				out_last_d = last_d;
			end
			ST_FETCH: begin
				slot_ctl.rd = 1'b1;
			end
			ST_RESULT: begin
				out_load = out_free;
			end
			ST_WRITEBACK: begin
				tbl_ctl.wr = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			gcnt_q      <= 32'd0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			first_q     <= 1'b0;
			kind_q      <= KIND_DELIVERED;
		end else begin
			st_q <= st_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (st_q == ST_LOOK) begin
				cnt_q   <= '0;
				first_q <= 1'b1;
				if (seq_eq) kind_q <= KIND_DELIVERED;
				else if (!seq_gt) kind_q <= KIND_STALE;
				else if (in_win) kind_q <= KIND_BUFFERED;
				else kind_q <= KIND_BEYOND;
			end
			if (st_q == ST_DELIVER && out_free) begin
				cnt_q   <= cnt_q + CW'(1);
				first_q <= 1'b0;
				gcnt_q  <= gcnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && accept) begin
			src_q <= msg.source_id;
			seq_q <= msg.seq_num;
			pl_q  <= msg.payload;
		end
		if (st_q == ST_LOOK) begin
			exp_q  <= rd_exp;
			base_q <= rd_base;
			if (seq_eq || (seq_gt && in_win)) begin
				vec_q <= rd_vec | ({{(WINDOW-1){1'b0}}, 1'b1} << look_idx);
			end else begin
				vec_q <= rd_vec;
			end
		end
		if (st_q == ST_DELIVER && out_free) begin
			vec_q[base_q] <= 1'b0;
			base_q        <= nxt_base;
			exp_q         <= exp_q + 32'd1;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_gseq_q <= out_gseq_d;
			out_src_q  <= src_q;
			out_pl_q   <= out_pl_d;
			out_last_q <= out_last_d;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.kind        = out_kind_q;
	assign res.global_seq  = out_gseq_q;
	assign res.out_source  = out_src_q;
	assign res.out_payload = out_pl_q;
	assign res.last        = out_last_q;

	a_drop_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_kind_d != KIND_DELIVERED |-> out_last_d)
		else $error("non-delivery result without last");

	a_gcnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_kind_d == KIND_DELIVERED |=> gcnt_q == $past(gcnt_q) + 32'd1)
		else $error("global counter did not advance on delivery");

	a_fetch_valid: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FETCH |-> vec_q[base_q])
		else $error("payload fetch from an empty slot");

	a_drain_limit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DELIVER |-> cnt_q < CW'(LIMIT))
		else $error("drain ran past its limit");

endmodule
